// ===== hw/rtl/fssa_pkg.sv =====
// fssa_pkg: shared constants, codes and control structs of the free stack slot allocator
`default_nettype none
package fssa_pkg;

    localparam int SLOTS          = 256;
    localparam int MAX_SLOT_BYTES = 4096;

    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int GRAN_W   = 13;
    localparam int CAP_W    = 9;
    localparam int OFF_W    = 21;
    localparam int MAG_W    = OFF_W - 1;
    localparam int OFFS_W   = 20;
    localparam int PROD_W   = SLOT_W + GRAN_W;
    localparam int REM_W    = GRAN_W;
    localparam int DCNT_W   = $clog2(MAG_W);
    localparam int STAT_W   = 2;

    localparam int S_TDATA_W = ((OFF_W + 7) / 8) * 8;
    localparam int M_FIELD_W = SLOT_W + OFFS_W + CAP_W + 3;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = GRAN_W;

    localparam logic [GRAN_W-1:0] GRAN_RESET = GRAN_W'(16);
    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRANULARITY = 2'd0,
        CFG_CAPACITY    = 2'd1
    } cfg_idx_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_POOL_FULL  = 2'd1,
        STAT_NOT_FOUND  = 2'd2,
        STAT_POOL_EMPTY = 2'd3
    } status_t;

    typedef enum logic {
        CMD_ACQUIRE = 1'b0,
        CMD_RELEASE = 1'b1
    } op_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic rd_link;
        logic exec;
    } fssa_cmd_t;

    typedef struct packed {
        logic is_release;
        logic is_neg;
        logic div_last;
    } fssa_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fssa_ram.sv =====
// fssa_ram: generic single write port ram with registered read
`default_nettype none
module fssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fssa_ctrl.sv =====
// fssa_ctrl: sequencing state machine and result handshake of the allocator
`default_nettype none
module fssa_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire fssa_pkg::fssa_stat_t stat,
    output fssa_pkg::fssa_cmd_t      cmd
);
    import fssa_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_EXEC = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_link = 1'b1;
                if (stat.is_release && !stat.is_neg) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_EXEC;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    cmd.exec     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fssa_dp.sv =====
// fssa_dp: pool state, link store, offset divider and result register of the allocator
`default_nettype none
module fssa_dp (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr,
    input  wire logic [fssa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fssa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [fssa_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                             s_tuser,
    output logic      [fssa_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic      [fssa_pkg::STAT_W-1:0]      m_tuser,
    input  wire fssa_pkg::fssa_cmd_t              cmd,
    output fssa_pkg::fssa_stat_t                  stat
);
    import fssa_pkg::*;

    logic [GRAN_W-1:0] gran_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [CAP_W-1:0]  used_reg, used_next;
    logic [SLOTS-1:0]  link_vld_reg;

    logic              op_reg;
    logic              neg_reg;
    logic [MAG_W-1:0]  dvd_reg;
    logic [MAG_W-1:0]  quo_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;

    logic [REM_W-1:0]  trial;
    logic              qbit;
    logic [GRAN_W-1:0] geff;
    logic [CAP_W-1:0]  ceff;

    logic [SLOT_W-1:0] link_rd;
    logic              link_we;
    logic [SLOT_W-1:0] idx;
    logic [SLOT_W-1:0] succ;
    status_t           status;
    logic              was_full;
    logic [PROD_W-1:0] prod;
    logic [OFFS_W-1:0] offs;

    always_comb begin
        if (gran_reg == '0) begin
            geff = GRAN_W'(1);
        end else if (gran_reg > GRAN_W'(MAX_SLOT_BYTES)) begin
            geff = GRAN_W'(MAX_SLOT_BYTES);
        end else begin
            geff = gran_reg;
        end
        if (cap_reg > CAP_W'(SLOTS)) begin
            ceff = CAP_W'(SLOTS);
        end else begin
            ceff = cap_reg;
        end
    end

    assign trial = {rem_reg[REM_W-2:0], dvd_reg[MAG_W-1]};
    assign qbit  = (trial >= geff);

    assign stat.is_release = (op_reg == CMD_RELEASE);
    assign stat.is_neg     = neg_reg;
    assign stat.div_last   = (dcnt_reg == DCNT_W'(MAG_W - 1));

    assign succ = (head_reg == SLOT_W'(SLOTS - 1)) ? '0 : head_reg + SLOT_W'(1);

    fssa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_we),
        .wr_addr (idx),
        .wr_data (head_reg),
        .rd_en   (cmd.rd_link),
        .rd_addr (head_reg),
        .rd_data (link_rd)
    );

    always_comb begin
        was_full  = (used_reg == ceff);
        status    = STAT_OK;
        idx       = '0;
        head_next = head_reg;
        used_next = used_reg;
        link_we   = 1'b0;
        if (op_reg == CMD_ACQUIRE) begin
            if (used_reg >= ceff) begin
                status = STAT_POOL_FULL;
            end else begin
                idx       = head_reg;
                head_next = link_vld_reg[head_reg] ? link_rd : succ;
                used_next = used_reg + CAP_W'(1);
            end
        end else begin
            if (neg_reg || rem_reg != '0 || quo_reg >= MAG_W'(ceff)) begin
                status = STAT_NOT_FOUND;
            end else if (used_reg == '0) begin
                status = STAT_POOL_EMPTY;
            end else begin
                idx       = quo_reg[SLOT_W-1:0];
                head_next = quo_reg[SLOT_W-1:0];
                used_next = used_reg - CAP_W'(1);
                link_we   = cmd.exec;
            end
        end
        prod = PROD_W'(idx) * PROD_W'(geff);
        offs = (status == STAT_OK) ? prod[OFFS_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gran_reg     <= GRAN_RESET;
            cap_reg      <= CAP_RESET;
            head_reg     <= '0;
            used_reg     <= '0;
            link_vld_reg <= '0;
        end else if (cfg_wr) begin
            if (cfg_index == CFG_GRANULARITY) begin
                gran_reg     <= cfg_data;
                head_reg     <= '0;
                used_reg     <= '0;
                link_vld_reg <= '0;
            end else if (cfg_index == CFG_CAPACITY) begin
                cap_reg      <= cfg_data[CAP_W-1:0];
                head_reg     <= '0;
                used_reg     <= '0;
                link_vld_reg <= '0;
            end
        end else if (cmd.exec) begin
            head_reg <= head_next;
            used_reg <= used_next;
            if (link_we) begin
                link_vld_reg[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_tuser;
            neg_reg  <= s_tdata[OFF_W-1];
            dvd_reg  <= s_tdata[MAG_W-1:0];
            quo_reg  <= '0;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            dvd_reg  <= {dvd_reg[MAG_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[MAG_W-2:0], qbit};
            rem_reg  <= qbit ? trial - geff : trial;
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end
        if (cmd.exec) begin
            m_tuser <= status;
            m_tdata <= M_TDATA_W'({was_full, (used_next == '0), (used_next == ceff),
                                   used_next, offs, idx});
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fixed_slot_free_stack_allocator_top.sv =====
// fixed_slot_free_stack_allocator_top: top level of the free stack slot allocator
//
//   channel  direction  handshake             payload
//   s_       in         s_tvalid / s_tready   s_tdata offset, s_tuser command
//   m_       out        m_tvalid / m_tready   m_tdata result fields, m_tuser status
//   cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// acquire: one link ram read, then the update, from accept to result
// release: the link ram read, then the 20 step restoring divider on the offset, then the update
// release of a negative offset skips the divider
// reset and every write to the granularity or capacity register empty the pool at once, no clearing pass
// a result held by m_tready stalls only the final update, the next item is still taken
`default_nettype none
module fixed_slot_free_stack_allocator_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [fssa_pkg::S_TDATA_W-1:0]   s_tdata,   // released_offset
    input  wire logic                             s_tuser,   // command
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // slot_index, slot_offset, used_count, now_full, now_empty, was_full
    output logic      [fssa_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic      [fssa_pkg::STAT_W-1:0]      m_tuser,   // status
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [fssa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fssa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fssa_pkg::*;

    fssa_cmd_t  cmd;
    fssa_stat_t stat;

    assign cfg_ready = 1'b1;

    fssa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fssa_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb_fixed_slot_free_stack_allocator_top.sv =====
// testbench: slot allocator checked against a free stack predictor under random stalls
`timescale 1ns / 100ps
module tb_fixed_slot_free_stack_allocator_top;
    import fssa_pkg::*;

    localparam int LONG_HOLD  = 400;
    localparam int END_SLACK  = 30;
    localparam int MAX_REPORT = 50;

    typedef struct packed {
        logic              was_full;
        logic              now_empty;
        logic              now_full;
        logic [CAP_W-1:0]  used_count;
        logic [OFFS_W-1:0] slot_offset;
        logic [SLOT_W-1:0] slot_index;
    } alloc_word_t;

    typedef struct {
        status_t     status;
        alloc_word_t word;
    } alloc_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STAT_W-1:0]     m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor state
    logic [GRAN_W-1:0] gran_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic [SLOT_W-1:0] pool_head;
    int unsigned       pool_used;
    logic [SLOT_W-1:0] pool_link [SLOTS];

    alloc_result_t alloc_pending[$];
    int            held_slots[$];

    logic quiet      = 1'b0;
    int   hold_token = 0;
    int   hold_seen  = 0;
    int   stall_left = 0;

    int mismatch_count = 0;
    int items_sent     = 0;
    int cfg_writes     = 0;
    int peak_used      = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    fixed_slot_free_stack_allocator_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic void clear_pool();
        pool_head = '0;
        pool_used = 0;
        for (int i = 0; i < SLOTS; i++) begin
            pool_link[i] = SLOT_W'(i + 1);
        end
    endfunction

    function automatic int unsigned eff_gran();
        if (gran_reg == 0) begin
            return 1;
        end
        if (gran_reg > MAX_SLOT_BYTES) begin
            return MAX_SLOT_BYTES;
        end
        return gran_reg;
    endfunction

    function automatic int unsigned eff_cap();
        if (cap_reg > SLOTS) begin
            return SLOTS;
        end
        return cap_reg;
    endfunction

    function automatic logic [OFF_W-1:0] slot_byte_offset(int unsigned slot);
        return OFF_W'(slot * eff_gran());
    endfunction

    function automatic alloc_result_t predict_alloc(op_t cmd, logic [OFF_W-1:0] raw);
        alloc_result_t res;
        int unsigned   g;
        int unsigned   c;
        int unsigned   q;
        int unsigned   idx;
        g = eff_gran();
        c = eff_cap();
        idx = 0;
        res.status = STAT_OK;
        res.word.was_full = (pool_used == c);
        if (cmd == CMD_ACQUIRE) begin
            if (pool_used >= c) begin
                res.status = STAT_POOL_FULL;
            end else begin
                idx = pool_head;
                pool_head = pool_link[idx];
                pool_used++;
            end
        end else if (raw[OFF_W-1]) begin
            res.status = STAT_NOT_FOUND;
        end else begin
            q = raw[OFF_W-2:0] / g;
            if ((raw[OFF_W-2:0] % g) != 0 || q >= c) begin
                res.status = STAT_NOT_FOUND;
            end else if (pool_used == 0) begin
                res.status = STAT_POOL_EMPTY;
            end else begin
                idx = q;
                pool_link[idx] = pool_head;
                pool_head = SLOT_W'(idx);
                pool_used--;
            end
        end
        res.word.slot_index  = SLOT_W'(idx);
        res.word.slot_offset = OFFS_W'(idx * g);
        res.word.used_count  = CAP_W'(pool_used);
        res.word.now_full    = (pool_used == c);
        res.word.now_empty   = (pool_used == 0);
        return res;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORT) begin
            $display("%0t ns: mismatch, %s", $time, what);
        end
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    always @(posedge aclk) begin : check_results
        alloc_result_t want;
        alloc_word_t   got;
        if (aresetn && m_tvalid && m_tready) begin
            got = alloc_word_t'(m_tdata);
            if (alloc_pending.size() == 0) begin
                report_mismatch("result with no item pending");
            end else begin
                want = alloc_pending.pop_front();
                status_seen[m_tuser]++;
                check_field("status", m_tuser, want.status);
                check_field("slot_index", got.slot_index, want.word.slot_index);
                check_field("slot_offset", got.slot_offset, want.word.slot_offset);
                check_field("used_count", got.used_count, want.word.used_count);
                check_field("now_full", got.now_full, want.word.now_full);
                check_field("now_empty", got.now_empty, want.word.now_empty);
                check_field("was_full", got.was_full, want.word.was_full);
            end
        end
    end

    // result side stalls, long hold on request
    always @(posedge aclk) begin
        if (hold_seen != hold_token) begin
            hold_seen  <= hold_token;
            stall_left <= LONG_HOLD - 1;
            m_tready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(1, 8) - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(op_t cmd, logic [OFF_W-1:0] offset);
        alloc_result_t want;
        int            gap;
        int            hit;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_W'(offset);
        do @(posedge aclk); while (!s_tready);
        want = predict_alloc(cmd, offset);
        alloc_pending.push_back(want);
        items_sent++;
        if (want.word.used_count > peak_used) begin
            peak_used = want.word.used_count;
        end
        if (want.status == STAT_OK) begin
            if (cmd == CMD_ACQUIRE) begin
                held_slots.push_back(want.word.slot_index);
            end else begin
                hit = -1;
                foreach (held_slots[i]) begin
                    if (hit < 0 && held_slots[i] == want.word.slot_index) begin
                        hit = i;
                    end
                end
                if (hit >= 0) begin
                    held_slots.delete(hit);
                end
            end
        end
    endtask

    task automatic finish_phase();
        s_tvalid <= 1'b0;
        while (alloc_pending.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_GRANULARITY) begin
            gran_reg = value;
        end else begin
            cap_reg = value[CAP_W-1:0];
        end
        clear_pool();
        cfg_writes++;
    endtask

    task automatic configure(logic [GRAN_W-1:0] gran, logic [CAP_W-1:0] cap);
        write_reg(CFG_GRANULARITY, gran);
        write_reg(CFG_CAPACITY, CFG_DATA_W'(cap));
        cfg_valid <= 1'b0;
        held_slots.delete();
    endtask

    task automatic send_random(int acq_pct);
        int                pick;
        int unsigned       g;
        int unsigned       lim;
        int unsigned       q;
        logic [OFF_W-1:0]  off;
        g = eff_gran();
        lim = (eff_cap() == 0) ? 0 : eff_cap() - 1;
        pick = $urandom_range(0, 99);
        if (pick < acq_pct) begin
            send_item(CMD_ACQUIRE, OFF_W'($urandom));
        end else if (pick < 88 && held_slots.size() != 0) begin
            send_item(CMD_RELEASE,
                slot_byte_offset(held_slots[$urandom_range(0, held_slots.size() - 1)]));
        end else begin
            q = $urandom_range(0, lim);
            case ($urandom_range(0, 4))
                0: begin
                    off = OFF_W'($urandom);
                end
                1: begin
                    off = {1'b1, OFFS_W'($urandom)};
                end
                2: begin
                    off = (g > 1) ? OFF_W'(q * g + $urandom_range(1, g - 1))
                                  : OFF_W'((lim + 1) * g);
                end
                3: begin
                    off = {1'b0, OFFS_W'((lim + 1 + $urandom_range(0, 3)) * g)};
                end
                default: begin
                    // may hit a slot that is already free
                    off = slot_byte_offset(q);
                end
            endcase
            send_item(CMD_RELEASE, off);
        end
    endtask

    task automatic test_directed_edges();
        // reset settings: 16 bytes per slot, 256 slots
        send_item(CMD_RELEASE, OFF_W'(0));
        send_item(CMD_RELEASE, '1);
        send_item(CMD_RELEASE, {1'b0, {OFFS_W{1'b1}}});
        send_item(CMD_RELEASE, OFF_W'(5));
        send_item(CMD_RELEASE, OFF_W'(4096));
        send_item(CMD_ACQUIRE, '1);
        send_item(CMD_ACQUIRE, OFF_W'(0));
        send_item(CMD_ACQUIRE, {1'b1, OFFS_W'(0)});
        send_item(CMD_RELEASE, OFF_W'(16));
        send_item(CMD_RELEASE, OFF_W'(16));
        send_item(CMD_ACQUIRE, OFF_W'(0));
        send_item(CMD_ACQUIRE, OFF_W'(0));
        finish_phase();
        // zero granularity and zero capacity
        configure('0, '0);
        send_item(CMD_ACQUIRE, OFF_W'(0));
        send_item(CMD_RELEASE, OFF_W'(0));
        finish_phase();
        // oversized granularity, single slot
        configure('1, CAP_W'(1));
        send_item(CMD_ACQUIRE, OFF_W'(0));
        send_item(CMD_ACQUIRE, OFF_W'(0));
        send_item(CMD_RELEASE, OFF_W'(MAX_SLOT_BYTES));
        send_item(CMD_RELEASE, OFF_W'(0));
        send_item(CMD_RELEASE, OFF_W'(0));
        finish_phase();
        // oversized capacity, top slot released while free
        configure(GRAN_W'(5000), '1);
        send_item(CMD_ACQUIRE, OFF_W'(0));
        send_item(CMD_RELEASE, OFF_W'((SLOTS - 1) * MAX_SLOT_BYTES));
        finish_phase();
    endtask

    task automatic test_fill_and_drain();
        configure(GRAN_W'(MAX_SLOT_BYTES), CAP_W'(SLOTS));
        hold_token <= hold_token + 1;
        repeat (SLOTS + 1) send_item(CMD_ACQUIRE, OFF_W'($urandom));
        while (held_slots.size() != 0) begin
            send_item(CMD_RELEASE,
                slot_byte_offset(held_slots[$urandom_range(0, held_slots.size() - 1)]));
        end
        send_item(CMD_RELEASE, OFF_W'(0));
        finish_phase();
    endtask

    task automatic test_random_phases();
        logic [GRAN_W-1:0] gran_set [10];
        logic [CAP_W-1:0]  cap_set [10];
        int                acq_pct;
        int                count;
        gran_set = '{13'd1, 13'd4096, 13'd16, 13'd0, 13'h1FFF,
                     13'd7, 13'd1, 13'd1, 13'd3, 13'd1};
        cap_set  = '{9'd1, 9'd256, 9'd2, 9'd3, 9'd300,
                     9'h1FF, 9'd1, 9'd1, 9'd0, 9'd1};
        foreach (gran_set[p]) begin
            if (p == 6 || p == 7 || p == 9) begin
                gran_set[p] = GRAN_W'($urandom_range(1, MAX_SLOT_BYTES));
                cap_set[p]  = CAP_W'($urandom_range(1, SLOTS));
            end
        end
        for (int p = 0; p < 10; p++) begin
            configure(gran_set[p], cap_set[p]);
            if (p == 9) begin
                quiet <= 1'b1;
            end
            acq_pct = $urandom_range(35, 65);
            count = (cap_set[p] == 0) ? 40 : 170;
            repeat (count) send_random(acq_pct);
            finish_phase();
        end
    endtask

    initial begin
        gran_reg = GRAN_RESET;
        cap_reg  = CAP_RESET;
        clear_pool();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_edges();
        test_fill_and_drain();
        test_random_phases();
        repeat (END_SLACK) @(posedge aclk);
        if (alloc_pending.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", alloc_pending.size()));
        end
        $display("ran %0d items over %0d register writes, peak occupancy %0d slots",
                 items_sent, cfg_writes, peak_used);
        $display("statuses seen: ok %0d, pool full %0d, bad offset %0d, pool empty %0d",
                 status_seen[STAT_OK], status_seen[STAT_POOL_FULL],
                 status_seen[STAT_NOT_FOUND], status_seen[STAT_POOL_EMPTY]);
        if (mismatch_count == 0) begin
            $display("tb_fixed_slot_free_stack_allocator_top OK");
        end else begin
            $display("tb_fixed_slot_free_stack_allocator_top NOT OK");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d results pending", alloc_pending.size());
        $display("tb_fixed_slot_free_stack_allocator_top NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/fssa_pkg.sv
hw/rtl/fssa_ram.sv
hw/rtl/fssa_ctrl.sv
hw/rtl/fssa_dp.sv
hw/rtl/fixed_slot_free_stack_allocator_top.sv
tb/sv/tb_fixed_slot_free_stack_allocator_top.sv
